// ===== rtl/core/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, controller states and the command/status bundles that join
// the exponentiation controller to its datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_CHECK,
    S_MUL,
    S_SQ_START,
    S_SQR,
    S_DONE
  } mexp_state_t;

  // operand routing for a modular multiply
  typedef enum logic {
    SEL_MULT,
    SEL_SQR
  } mexp_sel_t;

  typedef struct packed {
    logic      load;
    logic      start;
    mexp_sel_t sel;
    logic      step;
    logic      shift_exp;
    logic      publish;
  } mexp_cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_bit;
    logic exp_zero;
  } mexp_status_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
// ----------------------------------------------------------------------------
// mexp interfaces
// Valid/ready channels for exponentiation requests and results.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/core/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// Exponentiation datapath: running product, square, exponent shifter and a
// bit-serial reducing multiplier with a result register.
// ----------------------------------------------------------------------------
module mexp_dp (
  input  logic                           clk,
  input  mexp_pkg::mexp_cmd_t            cmd,
  input  logic [mexp_pkg::WIDTH-1:0]     modulus,
  input  logic [mexp_pkg::WIDTH-1:0]     base,
  input  logic [mexp_pkg::WIDTH-1:0]     exponent,
  output mexp_pkg::mexp_status_t         status,
  output logic [mexp_pkg::WIDTH-1:0]     result
);
  import mexp_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  // (x + y) mod m for x, y < m; m is one bit wider so zero means 2^WIDTH
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH:0]   m);
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - m;
    add_mod = (s >= m) ? d[WIDTH-1:0] : s[WIDTH-1:0];
  endfunction

  logic [WIDTH:0]   mext;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] exp_sr;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] macc;
  logic [WIDTH-1:0] macc_next;
  logic [WIDTH-1:0] dbl;
  logic [CNT_W-1:0] cnt;
  logic             dest_acc;
  logic             mod_one;

  assign mod_one = (modulus == WIDTH'(1));

  // one multiplier bit a cycle, most significant first
  always_comb begin
    dbl       = add_mod(macc, macc, mext);
    macc_next = mul_b[WIDTH-1] ? add_mod(dbl, mul_a, mext) : dbl;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mext     <= {(modulus == '0), modulus};
      // reduce the base by multiplying it with one
      mul_a    <= mod_one ? '0 : WIDTH'(1);
      mul_b    <= base;
      macc     <= '0;
      cnt      <= '0;
      dest_acc <= 1'b0;
      exp_sr   <= exponent;
      // a zero exponent gives one and is never reduced
      acc      <= (exponent == '0 || !mod_one) ? WIDTH'(1) : '0;
    end else if (cmd.start) begin
      mul_a    <= (cmd.sel == SEL_MULT) ? acc : sq;
      mul_b    <= sq;
      macc     <= '0;
      cnt      <= '0;
      dest_acc <= (cmd.sel == SEL_MULT);
    end else if (cmd.step) begin
      macc  <= macc_next;
      mul_b <= {mul_b[WIDTH-2:0], 1'b0};
      cnt   <= cnt + CNT_W'(1);
      if (cnt == CNT_LAST) begin
        if (dest_acc) begin
          acc <= macc_next;
        end else begin
          sq <= macc_next;
        end
      end
    end
    if (cmd.shift_exp) begin
      exp_sr <= {1'b0, exp_sr[WIDTH-1:1]};
    end
    if (cmd.publish) begin
      result <= acc;
    end
  end

  assign status.mul_last = (cnt == CNT_LAST);
  assign status.exp_bit  = exp_sr[0];
  assign status.exp_zero = (exp_sr == '0);

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square and multiply: walks the exponent bits, issues
// multiplier commands and holds the result-valid flag.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd
);
  import mexp_pkg::*;

  mexp_state_t state;
  mexp_state_t state_next;
  logic        can_publish;

  assign can_publish = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_RED;
      end
      S_RED: begin
        if (status.mul_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.exp_zero)     state_next = S_DONE;
        else if (status.exp_bit) state_next = S_MUL;
        else                     state_next = S_SQR;
      end
      S_MUL: begin
        if (status.mul_last) state_next = S_SQ_START;
      end
      S_SQ_START: state_next = S_SQR;
      S_SQR: begin
        if (status.mul_last) state_next = S_CHECK;
      end
      S_DONE: begin
        if (can_publish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.start     = 1'b0;
    cmd.sel       = SEL_SQR;
    cmd.step      = 1'b0;
    cmd.shift_exp = 1'b0;
    cmd.publish   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RED, S_MUL: cmd.step = 1'b1;
      S_CHECK: begin
        cmd.start = !status.exp_zero;
        cmd.sel   = status.exp_bit ? SEL_MULT : SEL_SQR;
      end
      S_SQ_START: cmd.start = 1'b1;
      S_SQR: begin
        cmd.step      = 1'b1;
        cmd.shift_exp = status.mul_last;
      end
      S_DONE: cmd.publish = can_publish;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// One request at a time. Every modular multiply runs on a single bit-serial
// reducing multiplier, one multiplier bit a cycle. A request first reduces the
// base, then for each exponent bit up to the highest set bit multiplies the
// running product by the square (set bits only) and squares the square, then
// hands over the result; with a zero exponent the bit loop is skipped. A
// finished result waits in an output register, so the next request is taken
// while it is still unread. A modulus of zero acts as 2^32.
// Write the modulus only while no request is in flight.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mexp_pkg::WIDTH-1:0]   cfg_wr_data,
  mexp_in_if.sink                      in_req,
  mexp_out_if.source                   out_rsp
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] modulus;
  mexp_cmd_t        cmd;
  mexp_status_t     status;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .modulus  (modulus),
    .base     (in_req.base),
    .exponent (in_req.exponent),
    .status   (status),
    .result   (out_rsp.result)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while a previous one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !out_rsp.valid || out_rsp.ready)
    else $error("unread result overwritten");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    out_rsp.valid && modulus != WIDTH'(0) && modulus != WIDTH'(1)
      |-> out_rsp.result < modulus)
    else $error("result not reduced by the modulus");
`endif

endmodule
